FILE: hw/rtl/rcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types and constants of the command stream parser.
// ----------------------------------------------------------------------------
package rcsp_pkg;

   localparam int MAX_ARGS        = 255;
   localparam int MAX_BULK_LENGTH = 65535;
   localparam int COUNTER_BITS    = 24;

   localparam int BYTE_W = 8;
   localparam int ARG_W  = 8;
   localparam int LEN_W  = 16;
   localparam int ACC_W  = $clog2(MAX_BULK_LENGTH + 2);
   localparam int MUL_W  = ACC_W + 4;
   localparam int KIND_W = 2;

   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_ARG_CLOSE = 2'd1,
      KIND_EMPTY_CMD = 2'd2,
      KIND_ERROR     = 2'd3
   } kind_type;

   typedef enum logic {
      ERR_FORMAT = 1'b0,
      ERR_LENGTH = 1'b1
   } err_type;

   typedef enum logic [8:0] {
      PH_STAR    = 9'b000000001,
      PH_ALEN    = 9'b000000010,
      PH_ALEN_LF = 9'b000000100,
      PH_DOLLAR  = 9'b000001000,
      PH_BLEN    = 9'b000010000,
      PH_BLEN_LF = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_PCR     = 9'b010000000,
      PH_PLF     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic                    valid;
      kind_type                kind;
      logic [BYTE_W-1:0]       payload_byte;
      logic [ARG_W-1:0]        arg_index;
      logic [LEN_W-1:0]        arg_length;
      logic                    command_done;
      logic [ARG_W-1:0]        arg_count;
      logic [COUNTER_BITS-1:0] cmd_byte_count;
      err_type                 error_code;
   } result_type;

endpackage

FILE: hw/rtl/rcsp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_core
// Parser state and one-byte step; produces at most one result per byte.
// ----------------------------------------------------------------------------
module rcsp_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [rcsp_pkg::BYTE_W-1:0]    data_byte,
   output rcsp_pkg::result_type           result
);
   import rcsp_pkg::*;

   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    digit_seen_ff, digit_seen_in;
   logic [ARG_W-1:0]        args_total_ff, args_total_in;
   logic [ARG_W-1:0]        cur_arg_ff, cur_arg_in;
   logic [LEN_W-1:0]        remaining_ff, remaining_in;
   logic [LEN_W-1:0]        plen_ff, plen_in;
   logic [COUNTER_BITS-1:0] cnt_ff, cnt_in;

   logic             is_digit;
   logic [MUL_W-1:0] acc_mul;
   logic [MUL_W-1:0] bound;
   logic             last_arg;

   always_comb begin
      is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      bound    = (phase_ff == PH_ALEN) ? MUL_W'(MAX_ARGS) : MUL_W'(MAX_BULK_LENGTH);
      acc_mul  = MUL_W'(acc_ff) * MUL_W'(10) + MUL_W'(data_byte - CH_ZERO);
      last_arg = ({1'b0, cur_arg_ff} + 9'd1) >= {1'b0, args_total_ff};
   end

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      args_total_in = args_total_ff;
      cur_arg_in    = cur_arg_ff;
      remaining_in  = remaining_ff;
      plen_in       = plen_ff;

      if (phase_ff == PH_STAR) begin
         cnt_in = COUNTER_BITS'(1);
      end else if (cnt_ff == CNT_MAX) begin
         cnt_in = cnt_ff;
      end else begin
         cnt_in = cnt_ff + COUNTER_BITS'(1);
      end

      result                = '0;
      result.arg_count      = args_total_ff;
      result.cmd_byte_count = cnt_in;

      case (phase_ff)
         PH_STAR: begin
            if (data_byte != CH_STAR) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_FORMAT;
            end else begin
               phase_in      = PH_ALEN;
               acc_in        = '0;
               digit_seen_in = 1'b0;
            end
         end
         PH_ALEN, PH_BLEN: begin
            if (is_digit) begin
               acc_in        = (acc_mul > bound) ? ACC_W'(bound + MUL_W'(1)) : ACC_W'(acc_mul);
               digit_seen_in = 1'b1;
            end else if (data_byte != CH_CR) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_LENGTH;
            end else begin
               phase_in = (phase_ff == PH_ALEN) ? PH_ALEN_LF : PH_BLEN_LF;
            end
         end
         PH_ALEN_LF: begin
            if (data_byte != CH_LF || !digit_seen_ff || acc_ff > ACC_W'(MAX_ARGS)) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_LENGTH;
            end else if (acc_ff == '0) begin
               result.valid        = 1'b1;
               result.kind         = KIND_EMPTY_CMD;
               result.command_done = 1'b1;
               result.arg_count    = '0;
            end else begin
               args_total_in = acc_ff[ARG_W-1:0];
               cur_arg_in    = '0;
               phase_in      = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (data_byte != CH_DOLLAR) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_FORMAT;
            end else begin
               phase_in      = PH_BLEN;
               acc_in        = '0;
               digit_seen_in = 1'b0;
            end
         end
         PH_BLEN_LF: begin
            if (data_byte != CH_LF || !digit_seen_ff
                || acc_ff > ACC_W'(MAX_BULK_LENGTH)) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_LENGTH;
            end else begin
               plen_in      = acc_ff[LEN_W-1:0];
               remaining_in = acc_ff[LEN_W-1:0];
               phase_in     = (acc_ff[LEN_W-1:0] == '0) ? PH_PCR : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = data_byte;
            result.arg_index    = cur_arg_ff;
            result.arg_length   = plen_ff;
            remaining_in        = remaining_ff - LEN_W'(1);
            if (remaining_ff == LEN_W'(1)) begin
               phase_in = PH_PCR;
            end
         end
         PH_PCR: begin
            if (data_byte != CH_CR) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_FORMAT;
            end else begin
               phase_in = PH_PLF;
            end
         end
         PH_PLF: begin
            if (data_byte != CH_LF) begin
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.error_code = ERR_FORMAT;
            end else begin
               result.valid        = 1'b1;
               result.kind         = KIND_ARG_CLOSE;
               result.arg_index    = cur_arg_ff;
               result.arg_length   = plen_ff;
               result.command_done = last_arg;
               if (!last_arg) begin
                  cur_arg_in = cur_arg_ff + ARG_W'(1);
                  phase_in   = PH_DOLLAR;
               end
            end
         end
         default: begin
            result.valid      = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_FORMAT;
         end
      endcase

      // errors and finished commands start over
      if (result.valid && (result.kind == KIND_ERROR || result.kind == KIND_EMPTY_CMD
                           || (result.kind == KIND_ARG_CLOSE && result.command_done))) begin
         phase_in      = PH_STAR;
         acc_in        = '0;
         digit_seen_in = 1'b0;
         args_total_in = '0;
         cur_arg_in    = '0;
         remaining_in  = '0;
         plen_in       = '0;
         cnt_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_STAR;
         acc_ff        <= '0;
         digit_seen_ff <= 1'b0;
         args_total_ff <= '0;
         cur_arg_ff    <= '0;
         remaining_ff  <= '0;
         plen_ff       <= '0;
         cnt_ff        <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         args_total_ff <= args_total_in;
         cur_arg_ff    <= cur_arg_in;
         remaining_ff  <= remaining_in;
         plen_ff       <= plen_in;
         cnt_ff        <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/resp_command_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_command_stream_parser_top
// Byte-stream parser for commands framed as arrays of length-prefixed strings.
//
// req_* takes one byte of the command stream per item. rsp_* gives zero or
// one result per byte: a payload byte, an argument close (tlast set on the
// command's last argument), an empty-command done (tlast set) or an error.
// Header bytes (markers, digits, CR, LF) give no result. After an error or a
// finished command the parser waits for the next '*'.
// A byte accepted goes into the input register; one step of the parse state
// then moves its result into the result register.
// Throughput: one byte per cycle unless a result waits with rsp_tready low;
// req then stays ready only while the input register is empty.
// When rsp_tready is low the result holds, the input register fills and
// then req_tready drops.
// Reset (synchronous) empties both registers and returns the parser to
// waiting for '*' with all counters cleared.
// ----------------------------------------------------------------------------
module resp_command_stream_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // payload_byte, arg_index, arg_length, arg_count,
                                    // cmd_byte_count, error_code, zero fill
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // command_done
);
   import rcsp_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              advance;
   result_type        step_res;
   logic              out_valid_ff;
   result_type        out_res_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   rcsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_res.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tlast  = out_res_ff.command_done;
   assign rsp_tdata  = {7'd0,
                        out_res_ff.error_code,
                        out_res_ff.cmd_byte_count,
                        out_res_ff.arg_count,
                        out_res_ff.arg_length,
                        out_res_ff.arg_index,
                        out_res_ff.payload_byte};

endmodule
